>>> sv/azcm_pkg.sv
`timescale 1ns / 1ps
// Types, codes and helpers shared by the angular zone membership check.
// No dependencies.
package azcm_pkg;

   localparam logic [15:0] FULL_TURN = 16'd36000;

   // Request action codes.
   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // Query kind codes.
   localparam logic [1:0] KIND_NO_FIRE     = 2'd0;
   localparam logic [1:0] KIND_NO_TRAVERSE = 2'd1;
   localparam logic [1:0] KIND_ALL         = 2'd2;

   // One stored zone; this is the word kept in the zone memory.
   typedef struct packed {
      logic [7:0]         id;
      logic               overridable;
      logic               kind;
      logic               enabled;
      logic [15:0]        az_start;
      logic [15:0]        az_end;
      logic signed [14:0] el_min;
      logic signed [14:0] el_max;
      logic [15:0]        rng_min;
      logic [15:0]        rng_max;
   } zone_type;

   // Point under test, held for the length of one scan.
   typedef struct packed {
      logic [15:0]        az;
      logic signed [14:0] el;
      logic signed [16:0] rng;
   } query_type;

   // Per-slot match flags from the evaluator.
   typedef struct packed {
      logic no_fire;
      logic no_traverse;
   } match_type;

   // First hit found for one kind.
   typedef struct packed {
      logic       found;
      logic [7:0] id;
      logic       kind;
      logic       overridable;
   } hit_type;

   function automatic logic [15:0] wrap_az(input logic [15:0] a);
      logic [15:0] r;
      r = (a >= FULL_TURN) ? a - FULL_TURN : a;
      return r;
   endfunction

endpackage

>>> sv/angular_zone_membership_check.sv
`timescale 1ns / 1ps
// Top level of the angular zone membership check: request decode, scan sequencer.
// Depends on azcm_pkg, azcm_ram and azcm_match.
//
//   channel   ports                 handshake
//   request   req_*                 start high while busy low takes the beat
//   result    rsp_*                 rsp_strobe marks a one-cycle result beat
//
// A write's all-zero result beat follows its acceptance in the next cycle, and
// the block is free again at once. A query walks every slot through the zone
// memory's single read port, one slot per cycle, and its result beat is
// registered in ST_DONE; busy is high through ST_SCAN and ST_DONE.
// Reset marks every slot empty through per-slot valid bits, with no clearing pass.
// The receiver cannot stall, so nothing holds a result back.
module angular_zone_membership_check #(
   parameter int ZONES = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_action,
   input  logic [3:0]         req_slot,
   input  logic [7:0]         req_zone_id,
   input  logic [2:0]         req_zone_flags,
   input  logic [15:0]        req_angle_lo,
   input  logic [15:0]        req_angle_hi,
   input  logic signed [14:0] req_elev_lo,
   input  logic signed [14:0] req_elev_hi,
   input  logic signed [16:0] req_dist_lo,
   input  logic [15:0]        req_dist_hi,
   input  logic [1:0]         req_query_kind,
   output logic               rsp_strobe,
   output logic               rsp_in_zone,
   output logic [7:0]         rsp_hit_zone_id,
   output logic               rsp_hit_kind,
   output logic               rsp_hit_overridable
);
   import azcm_pkg::*;

   localparam int AW = (ZONES > 1) ? $clog2(ZONES) : 1;
   localparam int CW = $clog2(ZONES + 1);
   localparam logic [CW-1:0] ZONES_C = CW'(ZONES);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   logic [CW-1:0] issue_ff, issue_in;
   logic       pend_ff, pend_in;
   logic       rd_valid_ff, rd_valid_in;
   logic [ZONES-1:0] valid_ff, valid_in;
   query_type  query_ff, query_in;
   logic [1:0] kind_ff, kind_in;
   hit_type    nf_hit_ff, nf_hit_in;
   hit_type    nt_hit_ff, nt_hit_in;
   logic       rsp_strobe_ff, rsp_strobe_in;
   hit_type    rsp_ff, rsp_in;

   logic       accept;
   logic       slot_ok;
   logic       ram_we;
   logic [AW-1:0] waddr;
   logic [AW-1:0] raddr;
   zone_type   wentry;
   zone_type   rentry;
   match_type  match;
   logic [15:0] dmin;

   assign accept  = start && (state_ff == ST_IDLE);
   assign busy    = (state_ff != ST_IDLE);
   assign slot_ok = (32'(req_slot) < ZONES);
   assign waddr   = AW'(req_slot);
   assign raddr   = issue_ff[AW-1:0];
   assign ram_we  = accept && (req_action == ACT_WRITE) && slot_ok;

   // A negative minimum range stores as zero; it matches the same points.
   assign dmin = req_dist_lo[16] ? 16'd0 : req_dist_lo[15:0];

   always_comb begin
      wentry.id          = req_zone_id;
      wentry.enabled     = req_zone_flags[0];
      wentry.kind        = req_zone_flags[1];
      wentry.overridable = req_zone_flags[2];
      wentry.az_start    = wrap_az(req_angle_lo);
      wentry.az_end      = wrap_az(req_angle_hi);
      wentry.el_min      = req_elev_lo;
      wentry.el_max      = req_elev_hi;
      wentry.rng_min     = dmin;
      wentry.rng_max     = req_dist_hi;
   end

   azcm_ram #(
      .WIDTH($bits(zone_type)),
      .DEPTH(ZONES)
   ) u_zone_ram (
      .clock(clock),
      .we(ram_we),
      .waddr(waddr),
      .wdata(wentry),
      .raddr(raddr),
      .rdata(rentry)
   );

   azcm_match u_match (
      .entry(rentry),
      .entry_valid(rd_valid_ff),
      .query(query_ff),
      .match(match)
   );

   always_comb begin
      state_in      = state_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      rd_valid_in   = rd_valid_ff;
      valid_in      = valid_ff;
      query_in      = query_ff;
      kind_in       = kind_ff;
      nf_hit_in     = nf_hit_ff;
      nt_hit_in     = nt_hit_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_WRITE) begin
                  if (slot_ok) begin
                     valid_in[waddr] = 1'b1;
                  end
                  rsp_strobe_in = 1'b1;
                  rsp_in        = '0;
               end else begin
                  query_in.az  = wrap_az(req_angle_lo);
                  query_in.el  = req_elev_lo;
                  query_in.rng = req_dist_lo;
                  kind_in      = req_query_kind;
                  issue_in     = '0;
                  nf_hit_in    = '0;
                  nt_hit_in    = '0;
                  state_in     = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // Read of slot n is issued while slot n-1 is being evaluated.
            if (issue_ff < ZONES_C) begin
               rd_valid_in = valid_ff[raddr];
               issue_in    = issue_ff + CW'(1);
               pend_in     = 1'b1;
            end
            if (pend_ff) begin
               if (match.no_fire && !nf_hit_ff.found) begin
                  nf_hit_in = '{found: 1'b1, id: rentry.id, kind: rentry.kind,
                                overridable: rentry.overridable};
               end
               if (match.no_traverse && !nt_hit_ff.found) begin
                  nt_hit_in = '{found: 1'b1, id: rentry.id, kind: rentry.kind,
                                overridable: rentry.overridable};
               end
               if (issue_ff == ZONES_C) begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            case (kind_ff)
               KIND_NO_FIRE:     rsp_in = nf_hit_ff;
               KIND_NO_TRAVERSE: rsp_in = nt_hit_ff;
               KIND_ALL:         rsp_in = nf_hit_ff.found ? nf_hit_ff : nt_hit_ff;
               default:          rsp_in = '0;
            endcase
            rsp_strobe_in = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issue_ff      <= '0;
         pend_ff       <= 1'b0;
         valid_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
         rsp_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         issue_ff      <= issue_in;
         pend_ff       <= pend_in;
         valid_ff      <= valid_in;
         rsp_strobe_ff <= rsp_strobe_in;
         rsp_ff        <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_valid_ff <= rd_valid_in;
      query_ff    <= query_in;
      kind_ff     <= kind_in;
      nf_hit_ff   <= nf_hit_in;
      nt_hit_ff   <= nt_hit_in;
   end

   assign rsp_strobe          = rsp_strobe_ff;
   assign rsp_in_zone         = rsp_ff.found;
   assign rsp_hit_zone_id     = rsp_ff.id;
   assign rsp_hit_kind        = rsp_ff.kind;
   assign rsp_hit_overridable = rsp_ff.overridable;

`ifndef SYNTHESIS
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      issue_ff <= ZONES_C)
      else $error("scan counter ran past the table");

   a_no_write_in_scan: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !ram_we)
      else $error("zone memory written during a scan");

   a_done_gives_beat: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> rsp_strobe_ff && state_ff == ST_IDLE)
      else $error("finished scan produced no result beat");

   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_ff.found |-> rsp_ff.id == 8'd0 && !rsp_ff.kind && !rsp_ff.overridable)
      else $error("result without a hit carries nonzero fields");
`endif

endmodule

>>> sv/azcm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module azcm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> sv/azcm_match.sv
`timescale 1ns / 1ps
// Tests one stored zone against the query point for both zone kinds.
// Depends on azcm_pkg.
module azcm_match (
   input  azcm_pkg::zone_type  entry,
   input  logic                entry_valid,
   input  azcm_pkg::query_type query,
   output azcm_pkg::match_type match
);
   import azcm_pkg::*;

   logic az_ok;
   logic el_ok;
   logic rng_ok;
   logic live;

   always_comb begin
      if (entry.az_start <= entry.az_end) begin
         az_ok = (query.az >= entry.az_start) && (query.az <= entry.az_end);
      end else begin
         az_ok = (query.az >= entry.az_start) || (query.az <= entry.az_end);
      end

      el_ok = (query.el >= entry.el_min) && (query.el <= entry.el_max);

      // A negative query range or a zone without bounds skips the range test.
      rng_ok = 1'b1;
      if (!query.rng[16] && (entry.rng_min != 16'd0 || entry.rng_max != 16'd0)) begin
         if (query.rng[15:0] < entry.rng_min) begin
            rng_ok = 1'b0;
         end
         if (entry.rng_max != 16'd0 && query.rng[15:0] > entry.rng_max) begin
            rng_ok = 1'b0;
         end
      end

      live = entry_valid && entry.enabled && az_ok && el_ok;
      match.no_fire     = live && !entry.kind && rng_ok;
      match.no_traverse = live && entry.kind;
   end

endmodule
